[rtl/hcr_pkg.sv]
// Shared constants and types for the height color ramp unit.
// Register indexes, field widths and reset values; no dependencies.
package hcr_pkg;

  localparam int AMP_W       = 15;
  localparam int SPREAD_W    = 16;
  localparam int COUNT_W     = 3;
  localparam int COLOR_W     = 32;
  localparam int HEIGHT_W    = 16;
  localparam int CHAN_W      = 8;
  localparam int NUM_CHANS   = 4;
  localparam int NUM_STOPS   = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam int FRAC_BITS_DEF = 16;

  localparam logic [COUNT_W-1:0] MIN_STOPS = 3'd2;
  localparam logic [COUNT_W-1:0] MAX_STOPS = 3'd5;

  localparam logic [AMP_W-1:0]    AMP_RESET    = 15'd16384;
  localparam logic [SPREAD_W-1:0] SPREAD_RESET = 16'd65535;
  localparam logic [COUNT_W-1:0]  COUNT_RESET  = 3'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AMPLITUDE  = 3'd0,
    REG_SPREAD     = 3'd1,
    REG_STOP_COUNT = 3'd2,
    REG_STOP_0     = 3'd3,
    REG_STOP_1     = 3'd4,
    REG_STOP_2     = 3'd5,
    REG_STOP_3     = 3'd6,
    REG_STOP_4     = 3'd7
  } cfg_reg_t;

endpackage

[rtl/height_color_ramp_unit.sv]
// Height color ramp unit: maps a signed height to a blended RGBA8888 color.
// Depends on hcr_pkg for register indexes, widths and reset values.
//
// One height enters per clock while in_stall is low. The depth is set by
// the normalizing divider, which resolves one quotient bit per pipeline
// stage, followed by stages for the stop scaling, the blend multiplies and
// the rounding sum. The whole pipeline holds while the output beat is
// stalled, so in_stall follows out_stall whenever a result is waiting.
// Configuration must only be written while no beat is in flight.
module height_color_ramp_unit #(
  parameter int FRAC_BITS = hcr_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [hcr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hcr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [hcr_pkg::HEIGHT_W-1:0] height,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [hcr_pkg::CHAN_W-1:0]        red,
  output logic [hcr_pkg::CHAN_W-1:0]        green,
  output logic [hcr_pkg::CHAN_W-1:0]        blue,
  output logic [hcr_pkg::CHAN_W-1:0]        alpha
);
  import hcr_pkg::*;

  localparam int PROD_W = AMP_W + SPREAD_W;
  localparam int DEN_W  = PROD_W + 1;
  localparam int HA_W   = HEIGHT_W + 1;
  localparam int NUM_W  = HA_W + SPREAD_W + 2;
  localparam int T_W    = FRAC_BITS + COUNT_W;
  localparam int PLO_W  = FRAC_BITS + CHAN_W + 1;
  localparam int PHI_W  = FRAC_BITS + CHAN_W;
  localparam int MIX_W  = FRAC_BITS + CHAN_W + 1;
  localparam logic [FRAC_BITS:0]   ONE  = (FRAC_BITS+1)'(1) << FRAC_BITS;
  localparam logic [MIX_W-1:0]     HALF = MIX_W'(1) << (FRAC_BITS - 1);

  // configuration registers
  logic [AMP_W-1:0]    amplitude;
  logic [SPREAD_W-1:0] spread;
  logic [COUNT_W-1:0]  stop_count;
  logic [COLOR_W-1:0]  stop_color [NUM_STOPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude     <= AMP_RESET;
      spread        <= SPREAD_RESET;
      stop_count    <= COUNT_RESET;
      stop_color[0] <= '0;
      stop_color[1] <= '1;
      stop_color[2] <= '0;
      stop_color[3] <= '0;
      stop_color[4] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_AMPLITUDE:  amplitude     <= cfg_data[AMP_W-1:0];
        REG_SPREAD:     spread        <= cfg_data[SPREAD_W-1:0];
        REG_STOP_COUNT: stop_count    <= cfg_data[COUNT_W-1:0];
        REG_STOP_0:     stop_color[0] <= cfg_data[COLOR_W-1:0];
        REG_STOP_1:     stop_color[1] <= cfg_data[COLOR_W-1:0];
        REG_STOP_2:     stop_color[2] <= cfg_data[COLOR_W-1:0];
        REG_STOP_3:     stop_color[3] <= cfg_data[COLOR_W-1:0];
        REG_STOP_4:     stop_color[4] <= cfg_data[COLOR_W-1:0];
        default:        amplitude     <= amplitude;
      endcase
    end
  end

  logic [AMP_W-1:0]    amp_eff;
  logic [SPREAD_W-1:0] spread_eff;
  logic [COUNT_W-1:0]  count_eff;
  logic [COUNT_W-1:0]  count_m1;

  always_comb begin
    amp_eff    = (amplitude == '0) ? AMP_W'(1) : amplitude;
    spread_eff = (spread == '0) ? SPREAD_W'(1) : spread;
    if (stop_count < MIN_STOPS) begin
      count_eff = MIN_STOPS;
    end else if (stop_count > MAX_STOPS) begin
      count_eff = MAX_STOPS;
    end else begin
      count_eff = stop_count;
    end
    count_m1 = count_eff - COUNT_W'(1);
  end

  // pipeline advance: the whole pipe holds while the output beat is stalled
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // stage 1: amplitude times spread, offset height
  logic              s1_valid;
  logic [HA_W-1:0]   s1_ha;
  logic [PROD_W-1:0] s1_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ha   <= {height[HEIGHT_W-1], height} + {2'b00, amp_eff};
      s1_prod <= PROD_W'({{SPREAD_W{1'b0}}, amp_eff} * {{AMP_W{1'b0}}, spread_eff});
    end
  end

  // stage 2: numerator, denominator, range checks
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  logic             num_zero;
  logic             num_sat;

  always_comb begin
    num      = {{2{s1_ha[HA_W-1]}}, s1_ha, {SPREAD_W{1'b0}}}
               - {{(NUM_W-PROD_W){1'b0}}, s1_prod};
    den      = {s1_prod, 1'b0};
    num_zero = num[NUM_W-1] || (num == '0);
    num_sat  = !num_zero && (num >= {{(NUM_W-DEN_W){1'b0}}, den});
  end

  logic                 dv_valid [FRAC_BITS+1];
  logic                 dv_zero  [FRAC_BITS+1];
  logic                 dv_sat   [FRAC_BITS+1];
  logic [DEN_W-1:0]     dv_rem   [FRAC_BITS+1];
  logic [DEN_W-1:0]     dv_den   [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] dv_quo   [FRAC_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (adv) begin
      dv_valid[0] <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_zero[0] <= num_zero;
      dv_sat[0]  <= num_sat;
      dv_rem[0]  <= (num_zero || num_sat) ? '0 : num[DEN_W-1:0];
      dv_den[0]  <= den;
      dv_quo[0]  <= '0;
    end
  end

  // restoring divider: one quotient bit per stage
  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
    logic [DEN_W:0] shifted;
    logic           ge;

    always_comb begin
      shifted = {dv_rem[k], 1'b0};
      ge      = shifted >= {1'b0, dv_den[k]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[k+1] <= 1'b0;
      end else if (adv) begin
        dv_valid[k+1] <= dv_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_zero[k+1] <= dv_zero[k];
        dv_sat[k+1]  <= dv_sat[k];
        dv_den[k+1]  <= dv_den[k];
        dv_rem[k+1]  <= ge ? DEN_W'(shifted - {1'b0, dv_den[k]}) : shifted[DEN_W-1:0];
        dv_quo[k+1]  <= {dv_quo[k][FRAC_BITS-2:0], ge};
      end
    end
  end

  // stage 3: scale by stop count minus one, split index and fraction
  logic [FRAC_BITS-1:0] v;
  logic [T_W-1:0]       t;
  logic [COUNT_W-1:0]   idx_raw;
  logic [COUNT_W-1:0]   idx_max;

  always_comb begin
    if (dv_zero[FRAC_BITS]) begin
      v = '0;
    end else if (dv_sat[FRAC_BITS]) begin
      v = '1;
    end else begin
      v = dv_quo[FRAC_BITS];
    end
    t       = {{COUNT_W{1'b0}}, v} * {{FRAC_BITS{1'b0}}, count_m1};
    idx_raw = t[T_W-1:FRAC_BITS];
    idx_max = count_m1 - COUNT_W'(1);
  end

  logic                 s3_valid;
  logic [COUNT_W-1:0]   s3_idx;
  logic [FRAC_BITS-1:0] s3_frac;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= dv_valid[FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_idx  <= (idx_raw > idx_max) ? idx_max : idx_raw;
      s3_frac <= t[FRAC_BITS-1:0];
    end
  end

  // stage 4: pick the stop pair, weight each channel
  logic [COLOR_W-1:0]   c_lo;
  logic [COLOR_W-1:0]   c_hi;
  logic [FRAC_BITS:0]   w_lo;
  logic [PLO_W-1:0]     p_lo_next [NUM_CHANS];
  logic [PHI_W-1:0]     p_hi_next [NUM_CHANS];

  always_comb begin
    unique case (s3_idx)
      3'd0: begin
        c_lo = stop_color[0];
        c_hi = stop_color[1];
      end
      3'd1: begin
        c_lo = stop_color[1];
        c_hi = stop_color[2];
      end
      3'd2: begin
        c_lo = stop_color[2];
        c_hi = stop_color[3];
      end
      3'd3: begin
        c_lo = stop_color[3];
        c_hi = stop_color[4];
      end
      default: begin
        c_lo = stop_color[0];
        c_hi = stop_color[1];
      end
    endcase
    w_lo = ONE - {1'b0, s3_frac};
    for (int ch = 0; ch < NUM_CHANS; ch++) begin
      p_lo_next[ch] = {{(FRAC_BITS+1){1'b0}}, c_lo[COLOR_W-1-CHAN_W*ch -: CHAN_W]}
                      * {{CHAN_W{1'b0}}, w_lo};
      p_hi_next[ch] = {{FRAC_BITS{1'b0}}, c_hi[COLOR_W-1-CHAN_W*ch -: CHAN_W]}
                      * {{CHAN_W{1'b0}}, s3_frac};
    end
  end

  logic             s4_valid;
  logic [PLO_W-1:0] s4_p_lo [NUM_CHANS];
  logic [PHI_W-1:0] s4_p_hi [NUM_CHANS];

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ch = 0; ch < NUM_CHANS; ch++) begin
        s4_p_lo[ch] <= p_lo_next[ch];
        s4_p_hi[ch] <= p_hi_next[ch];
      end
    end
  end

  // stage 5: round to nearest, output register
  logic [MIX_W-1:0]  mix [NUM_CHANS];
  logic [CHAN_W-1:0] chan [NUM_CHANS];

  always_comb begin
    for (int ch = 0; ch < NUM_CHANS; ch++) begin
      mix[ch] = s4_p_lo[ch] + {1'b0, s4_p_hi[ch]} + HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ch = 0; ch < NUM_CHANS; ch++) begin
        chan[ch] <= mix[ch][FRAC_BITS+CHAN_W-1:FRAC_BITS];
      end
    end
  end

  assign red   = chan[0];
  assign green = chan[1];
  assign blue  = chan[2];
  assign alpha = chan[3];

endmodule
